/* rtl/rtc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types and constants for the RTD code to temperature pipeline.
// ----------------------------------------------------------------------------
package rtc_pkg;

    localparam int RAD_W   = 58;   // discriminant width, units of 1e-22
    localparam int ROOT_W  = 29;   // square root width, units of 1e-11
    localparam int REM_W   = 31;   // partial remainder width of the root
    localparam int TEMP_W  = 20;
    localparam int STAT_W  = 3;
    localparam int SQRT_STEPS = ROOT_W;

    // Register indexes of the configuration channel.
    localparam logic [7:0] REG_REFERENCE_OHMS = 8'd0;
    localparam logic [7:0] REG_SENSOR_KIND    = 8'd1;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_FAULT     = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_REF    = 3'd2;
    localparam logic [STAT_W-1:0] ST_DISC_NEG  = 3'd3;
    localparam logic [STAT_W-1:0] ST_SATURATED = 3'd4;

    // Discriminant is DISC_K - ceil(N * M / 2^k), with M and k set by R0.
    localparam logic [RAD_W-1:0] DISC_K = 58'd175848088900000000;
    localparam logic [35:0] SCALE_M_100  = 36'd56396484375;  // 231 * 5^12, k = 3
    localparam logic [35:0] SCALE_M_1000 = 36'd11279296875;  // 231 * 5^11, k = 4

    // Temperature = round((A_ROOT - S) / 1155), via reciprocal 2^40 / 1155.
    localparam logic [29:0] A_ROOT    = 30'd390830000;
    localparam logic [29:0] DIV_HALF  = 30'd577;
    localparam logic [29:0] DIV_RECIP = 30'd951958120;
    localparam int          DIV_SHIFT = 40;

    localparam logic signed [TEMP_W:0] TEMP_FAIL = -21'sd27315;
    localparam logic signed [TEMP_W:0] TEMP_MAX  = 21'sd338500;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [RAD_W-1:0]  rad;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } cell_t;

endpackage

/* rtl/rtc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_front
// Scales the ratio code and forms the discriminant over three stages.
// ----------------------------------------------------------------------------
module rtc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               in_vld,
    input  logic [15:0]        rtd_word,
    input  logic [15:0]        reference_ohms,
    input  logic               sensor_kind,
    output logic               out_vld,
    output rtc_pkg::cell_t     out_cell
);
    import rtc_pkg::*;

    logic              a_vld_reg, b_vld_reg, c_vld_reg;
    logic [STAT_W-1:0] a_status_reg, b_status_reg;
    logic [30:0]       a_n_reg;
    logic              a_kind_reg, b_kind_reg;
    logic [51:0]       b_plo_reg;
    logic [50:0]       b_phi_reg;
    cell_t             c_cell_reg;

    logic [STAT_W-1:0] a_status_next, c_status_next;
    logic [35:0]       scale_m;
    logic [66:0]       prod;
    logic [66:0]       prod_round;
    logic [63:0]       term;
    logic              disc_neg;

    always_comb begin
        if (reference_ohms == 16'd0) begin
            a_status_next = ST_NO_REF;
        end else if (rtd_word[0]) begin
            a_status_next = ST_FAULT;
        end else begin
            a_status_next = ST_OK;
        end
    end

    assign scale_m = a_kind_reg ? SCALE_M_1000 : SCALE_M_100;

    assign prod       = {15'd0, b_plo_reg} + {b_phi_reg, 16'd0};
    assign prod_round = prod + (b_kind_reg ? 67'd15 : 67'd7);
    assign term       = b_kind_reg ? {1'b0, prod_round[66:4]} : prod_round[66:3];
    assign disc_neg   = term > {6'd0, DISC_K};

    always_comb begin
        c_status_next = b_status_reg;
        if (b_status_reg == ST_OK && disc_neg) begin
            c_status_next = ST_DISC_NEG;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else if (advance) begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_status_reg <= a_status_next;
            a_n_reg      <= 31'(rtd_word[15:1]) * 31'(reference_ohms);
            a_kind_reg   <= sensor_kind;
            b_status_reg <= a_status_reg;
            b_kind_reg   <= a_kind_reg;
            b_plo_reg    <= scale_m * a_n_reg[15:0];
            b_phi_reg    <= scale_m * a_n_reg[30:16];
            c_cell_reg.status <= c_status_next;
            c_cell_reg.rad    <= disc_neg ? '0 : DISC_K - term[RAD_W-1:0];
            c_cell_reg.root   <= '0;
            c_cell_reg.rem    <= '0;
        end
    end

    assign out_vld  = c_vld_reg;
    assign out_cell = c_cell_reg;

endmodule

/* rtl/rtc_sqrt_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_sqrt_cell
// One restoring square root step: takes two radicand bits, yields one root bit.
// ----------------------------------------------------------------------------
module rtc_sqrt_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           advance,
    input  logic           in_vld,
    input  rtc_pkg::cell_t in_cell,
    output logic           out_vld,
    output rtc_pkg::cell_t out_cell
);
    import rtc_pkg::*;

    logic        vld_reg;
    cell_t       cell_reg;
    cell_t       cell_next;
    logic [32:0] rem_shift;
    logic [32:0] trial;

    assign rem_shift = {in_cell.rem, in_cell.rad[RAD_W-1 -: 2]};
    assign trial     = {2'b00, in_cell.root, 2'b01};

    always_comb begin
        cell_next        = in_cell;
        cell_next.rad    = {in_cell.rad[RAD_W-3:0], 2'b00};
        if (rem_shift >= trial) begin
            cell_next.rem  = REM_W'(rem_shift - trial);
            cell_next.root = {in_cell.root[ROOT_W-2:0], 1'b1};
        end else begin
            cell_next.rem  = rem_shift[REM_W-1:0];
            cell_next.root = {in_cell.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (advance) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            cell_reg <= cell_next;
        end
    end

    assign out_vld  = vld_reg;
    assign out_cell = cell_reg;

endmodule

/* rtl/rtc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_back
// Turns the root into rounded hundredths of a degree and clamps the result.
// ----------------------------------------------------------------------------
module rtc_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          in_vld,
    input  rtc_pkg::cell_t                in_cell,
    output logic                          out_vld,
    output logic [rtc_pkg::TEMP_W-1:0]    temperature_centi,
    output logic [rtc_pkg::STAT_W-1:0]    status
);
    import rtc_pkg::*;

    logic              d_vld_reg, e_vld_reg;
    logic              d_neg_reg;
    logic [STAT_W-1:0] d_status_reg, e_status_reg;
    logic [59:0]       d_prod_reg;
    logic [TEMP_W-1:0] e_temp_reg;

    logic signed [30:0] num;
    logic [29:0]        mag;
    logic [29:0]        mag_round;
    logic [TEMP_W-1:0]  quot;
    logic signed [TEMP_W:0] temp_s;
    logic [TEMP_W-1:0]  e_temp_next;
    logic [STAT_W-1:0]  e_status_next;

    assign num       = $signed({1'b0, A_ROOT}) - $signed({2'b00, in_cell.root});
    assign mag       = num[30] ? 30'(-num) : num[29:0];
    assign mag_round = mag + DIV_HALF;

    assign quot   = d_prod_reg[DIV_SHIFT +: TEMP_W];
    assign temp_s = d_neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    always_comb begin
        e_status_next = d_status_reg;
        e_temp_next   = TEMP_FAIL[TEMP_W-1:0];
        if (d_status_reg == ST_OK) begin
            if (temp_s > TEMP_MAX) begin
                e_status_next = ST_SATURATED;
                e_temp_next   = TEMP_MAX[TEMP_W-1:0];
            end else if (temp_s < TEMP_FAIL) begin
                e_status_next = ST_SATURATED;
            end else begin
                e_temp_next = temp_s[TEMP_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
        end else if (advance) begin
            d_vld_reg <= in_vld;
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            d_neg_reg    <= num[30];
            d_status_reg <= in_cell.status;
            d_prod_reg   <= mag_round * DIV_RECIP;
            e_status_reg <= e_status_next;
            e_temp_reg   <= e_temp_next;
        end
    end

    assign out_vld           = e_vld_reg;
    assign temperature_centi = e_temp_reg;
    assign status            = e_status_reg;

endmodule

/* rtl/rtd_code_to_temperature.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtd_code_to_temperature
// Converts RTD converter words to temperature through an inverse quadratic.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word contents (low bit first)
//  s_*       in         [15:0] rtd_word
//  m_*       out        [19:0] temperature_centi, [22:20] status, [23] zero
//  cfg_*     in         index 0 reference_ohms (16 bit), 1 sensor_kind (1 bit)
//
//  One word is accepted every cycle while the pipeline is not held; each word
//  passes 34 register stages: three scaling stages, one square root cell per
//  root bit (29 cells), and two conversion stages including the output
//  register, from which its result is shown on m_*.
//  Reset is synchronous and active low; it clears the valid bits and the configuration registers.
//  The whole pipeline holds while a result waits at m_tvalid with m_tready low.
// ----------------------------------------------------------------------------
module rtd_code_to_temperature (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // [15:0] rtd_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,      // [19:0] temperature_centi, [22:20] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import rtc_pkg::*;

    logic [15:0] reference_ohms_reg;
    logic        sensor_kind_reg;
    logic        advance;

    logic  chain_vld  [0:SQRT_STEPS];
    cell_t chain_cell [0:SQRT_STEPS];

    logic [TEMP_W-1:0] temperature_centi;
    logic [STAT_W-1:0] status;

    // Every stage moves together whenever the output register is free or
    // its word is being taken this cycle.
    assign advance   = !m_tvalid || m_tready;
    assign s_tready  = advance;
    assign cfg_ready = 1'b1;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reference_ohms_reg <= '0;
            sensor_kind_reg    <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == REG_REFERENCE_OHMS) begin
                reference_ohms_reg <= cfg_data;
            end else if (cfg_index == REG_SENSOR_KIND) begin
                sensor_kind_reg <= cfg_data[0];
            end
        end
    end

    rtc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .in_vld         (s_tvalid),
        .rtd_word       (s_tdata),
        .reference_ohms (reference_ohms_reg),
        .sensor_kind    (sensor_kind_reg),
        .out_vld        (chain_vld[0]),
        .out_cell       (chain_cell[0])
    );

    // The square root runs down a row of cells, one root bit per cell.
    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        rtc_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .in_vld   (chain_vld[i]),
            .in_cell  (chain_cell[i]),
            .out_vld  (chain_vld[i+1]),
            .out_cell (chain_cell[i+1])
        );
    end

    rtc_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .advance           (advance),
        .in_vld            (chain_vld[SQRT_STEPS]),
        .in_cell           (chain_cell[SQRT_STEPS]),
        .out_vld           (m_tvalid),
        .temperature_centi (temperature_centi),
        .status            (status)
    );

    assign m_tdata = {1'b0, status, temperature_centi};

`ifndef SYNTHESIS
    // Any failure status carries the failure temperature.
    a_fail_temp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (status == ST_FAULT || status == ST_NO_REF || status == ST_DISC_NEG)
        |-> $signed(temperature_centi) == TEMP_FAIL)
        else $error("failure status without failure temperature");

    // A saturated result sits on one of the two limits.
    a_sat_temp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status == ST_SATURATED
        |-> $signed(temperature_centi) == TEMP_MAX
            || $signed(temperature_centi) == TEMP_FAIL)
        else $error("saturated result off the limits");

    // A good result lies inside the field range.
    a_ok_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status == ST_OK
        |-> $signed(temperature_centi) >= TEMP_FAIL
            && $signed(temperature_centi) <= TEMP_MAX)
        else $error("good result out of range");

    // Status never takes a code beyond saturation.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> status <= ST_SATURATED)
        else $error("unknown status code");
`endif

endmodule
